@@ hdl/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// pba_pkg: shared types and constants of the pooled bump allocator
// Request and response payloads, status codes, register indexes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int unsigned POOL_COUNT_DEF = 16;
    localparam int unsigned CHUNK_BYTES    = 20 * 1024;

    localparam logic [31:0] CAP_RESET   = 32'h0010_0000;
    localparam logic [24:0] STEP_RESET  = 25'h010_0000;
    localparam logic [31:0] LIMIT_RESET = 32'h0000_0000;

    // register indexes
    localparam logic [1:0] CFG_INIT_CAP   = 2'd0;
    localparam logic [1:0] CFG_GROW_STEP  = 2'd1;
    localparam logic [1:0] CFG_SIZE_LIMIT = 2'd2;

    // request kinds
    localparam logic FUNC_POOL = 1'b0;
    localparam logic FUNC_RAW  = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_POOL   = 3'd2;
    localparam logic [2:0] ST_LIMIT     = 3'd3;
    localparam logic [2:0] ST_NO_GROW   = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;

    typedef struct packed {
        logic        func;
        logic [31:0] req_size;
        logic [15:0] alignment;
    } req_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [2:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [14:0] item_size;
        logic [14:0] remaining;
        logic [31:0] next_offset;
    } pool_ent_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_FAIL,
        OP_SCAN_START,
        OP_SCAN,
        OP_PICK,
        OP_READ,
        OP_LOAD_ENTRY,
        OP_RAW_REQ,
        OP_RAW_CHUNK,
        OP_BASE,
        OP_END,
        OP_COMMIT,
        OP_X,
        OP_CAP_X,
        OP_Y,
        OP_RAW_RESULT,
        OP_CHUNK_OFF,
        OP_CHUNK_REM,
        OP_ITEM,
        OP_ITEM_RES,
        OP_WRITE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        DIV_ALN,
        DIV_LIM,
        DIV_NEED,
        DIV_CHUNK,
        DIV_ITEM
    } div_sel_t;

    typedef struct packed {
        op_t        op;
        logic       div_start;
        div_sel_t   div_sel;
        logic [2:0] code;
    } ctl_t;

    typedef struct packed {
        logic is_raw;
        logic req_zero;
        logic req_big;
        logic div_busy;
        logic scan_last;
        logic hit_found;
        logic empty_found;
        logic rem_zero;
        logic aln_zero;
        logic end_ovf;
        logic end_fits;
        logic at_limit;
        logic step_zero;
        logic limit_on;
        logic x_lt_end;
        logic out_free;
    } stat_t;

    // saturate a 33-bit sum to 32 bits
    function automatic logic [31:0] sat32(input logic [32:0] v);
        return v[32] ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

@@ hdl/pooled_bump_allocator_top.sv @@
// ----------------------------------------------------------------------------
// pooled_bump_allocator_top: size-class pool allocator over a bump arena
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | in        | in_valid / in_stall   | req_t: func, size, align
//   out     | out       | out_valid / out_stall | rsp_t: value, status
//   cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// One request at a time. Each division holds the sequencer on the shared
// radix-2 divider; a raw request makes up to three divisions (alignment,
// limit, growth). A pooled request adds a scan of the pool memory, one slot
// per cycle, the slot setup states (pick, read, load, entry), and up to two
// more divisions (chunk count, item index).
// Reset clears the pool valid bits at once; no clearing pass is needed.
// The next request is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module pooled_bump_allocator_top
    import pba_pkg::*;
#(
    parameter int unsigned POOL_COUNT = POOL_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output rsp_t        out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ctl_t  ctl;
    stat_t stat;

    pba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    pba_dp #(
        .POOL_COUNT (POOL_COUNT)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ hdl/pba_div.sv @@
// ----------------------------------------------------------------------------
// pba_div: radix-2 restoring divider
// 32-bit dividend by 25-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pba_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [24:0] divisor,
    output logic        busy,
    output logic [31:0] quotient,
    output logic [24:0] remainder
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [24:0] rem_reg;
    logic [24:0] dvs_reg;

    logic [25:0] shifted;
    logic        ge;
    logic [25:0] diff;

    // one trial subtraction per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[31]};
        ge      = shifted >= {1'b0, dvs_reg};
        diff    = shifted - {1'b0, dvs_reg};
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // quotient and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], ge};
            rem_reg <= ge ? diff[24:0] : shifted[24:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/pba_dp.sv @@
// ----------------------------------------------------------------------------
// pba_dp: allocator datapath
// Arena and register state, pool table memory with valid bits, the shared
// divider, operand selection, and the output register.
// ----------------------------------------------------------------------------
module pba_dp
    import pba_pkg::*;
#(
    parameter int unsigned POOL_COUNT = POOL_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    output stat_t       stat,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output rsp_t        out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned IDX_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int unsigned PTR_W = $clog2(POOL_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POOL_COUNT - 1);
    localparam logic [PTR_W-1:0] PTR_END   = PTR_W'(POOL_COUNT);
    localparam logic [31:0]      CHUNK32   = 32'(CHUNK_BYTES);

    // arena and registers
    logic [31:0] cap_reg, used_reg, limit_reg;
    logic [24:0] step_reg;

    // request and raw operands
    req_t        req_reg;
    logic [31:0] sz_reg;
    logic [15:0] al_reg;
    logic [32:0] base_reg;
    logic [33:0] end_reg;
    logic [32:0] tmp_reg;

    // pool table
    pool_ent_t              pool_mem [POOL_COUNT];
    pool_ent_t              pool_q_reg;
    logic                   q_vld_reg;
    logic [POOL_COUNT-1:0]  pool_vld_reg;
    logic [IDX_W-1:0]       rd_addr;
    pool_ent_t              q_ent;

    // scan state
    logic [PTR_W-1:0] ptr_reg;
    logic             q_scan_reg;
    logic [IDX_W-1:0] q_idx_reg;
    logic             hit_f_reg, emp_f_reg;
    logic [IDX_W-1:0] hit_idx_reg, emp_idx_reg;
    logic [IDX_W-1:0] sel_reg;
    logic             claim_reg;

    // working entry
    logic [14:0] w_size_reg, w_rem_reg;
    logic [31:0] w_off_reg;

    // result and output
    logic [31:0] res_value_reg;
    logic [2:0]  res_status_reg;
    rsp_t        out_reg;
    logic        out_vld_reg;

    // divider
    logic [31:0] div_dvd;
    logic [24:0] div_dvs;
    logic        div_busy;
    logic [31:0] div_q;
    logic [24:0] div_r;

    logic [24:0] pad;
    logic [32:0] base_calc, x_calc, y_calc;
    logic [33:0] end_calc;
    logic        out_free;

    pba_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctl.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // divider operand select
    always_comb
    begin
        case (ctl.div_sel)
            DIV_ALN:
            begin
                div_dvd = used_reg;
                div_dvs = {9'd0, al_reg};
            end
            DIV_LIM:
            begin
                div_dvd = limit_reg - cap_reg;
                div_dvs = step_reg;
            end
            DIV_NEED:
            begin
                div_dvd = end_reg[31:0] - cap_reg;
                div_dvs = step_reg;
            end
            DIV_CHUNK:
            begin
                div_dvd = CHUNK32;
                div_dvs = {10'd0, req_reg.req_size[14:0]};
            end
            default:
            begin
                div_dvd = w_off_reg;
                div_dvs = {10'd0, req_reg.req_size[14:0]};
            end
        endcase
    end

    // alignment, end and growth arithmetic
    always_comb
    begin
        pad       = (div_r == '0) ? '0 : step_reg - div_r;
        base_calc = (al_reg == '0) ? {1'b0, used_reg}
                  : {1'b0, used_reg} + {17'd0, al_reg} - {17'd0, div_r[15:0]};
        end_calc  = {1'b0, base_reg} + {2'b0, sz_reg};
        x_calc    = {1'b0, limit_reg} + {8'd0, pad};
        y_calc    = end_reg[32:0] + {8'd0, pad};
    end

    // pool read: entries never written read as unused
    assign rd_addr = (ctl.op == OP_SCAN) ? ptr_reg[IDX_W-1:0] : sel_reg;

    always_comb
    begin
        q_ent             = pool_q_reg;
        q_ent.item_size   = q_vld_reg ? pool_q_reg.item_size : '0;
        q_ent.remaining   = q_vld_reg ? pool_q_reg.remaining : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_WRITE)
        begin
            pool_mem[sel_reg] <= '{item_size: w_size_reg, remaining: w_rem_reg,
                                   next_offset: w_off_reg};
        end
        pool_q_reg <= pool_mem[rd_addr];
        q_vld_reg  <= pool_vld_reg[rd_addr];
    end

    assign out_free = !out_vld_reg || !out_stall;

    // control state, arena and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            step_reg     <= STEP_RESET;
            limit_reg    <= LIMIT_RESET;
            used_reg     <= '0;
            pool_vld_reg <= '0;
            ptr_reg      <= '0;
            q_scan_reg   <= 1'b0;
            hit_f_reg    <= 1'b0;
            emp_f_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            // output register
            if (ctl.op == OP_EMIT)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end

            // scan pipeline
            q_scan_reg <= 1'b0;
            if (ctl.op == OP_SCAN_START)
            begin
                ptr_reg   <= '0;
                hit_f_reg <= 1'b0;
                emp_f_reg <= 1'b0;
            end
            else if (ctl.op == OP_SCAN && ptr_reg < PTR_END)
            begin
                ptr_reg    <= ptr_reg + 1'b1;
                q_scan_reg <= 1'b1;
            end
            if (q_scan_reg)
            begin
                if (!hit_f_reg && q_ent.item_size == req_reg.req_size[14:0])
                begin
                    hit_f_reg <= 1'b1;
                end
                if (q_ent.item_size == '0)
                begin
                    emp_f_reg <= 1'b1;
                end
            end

            if (ctl.op == OP_WRITE)
            begin
                pool_vld_reg[sel_reg] <= 1'b1;
            end

            // arena updates
            case (ctl.op)
                OP_COMMIT: used_reg <= end_reg[31:0];
                OP_CAP_X:  cap_reg  <= sat32(tmp_reg);
                OP_Y:      cap_reg  <= sat32(y_calc);
                default:   ;
            endcase

            // configuration writes must arrive only while idle; the block does not enforce it
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INIT_CAP:   cap_reg   <= cfg_data;
                    CFG_GROW_STEP:  step_reg  <= cfg_data[24:0];
                    CFG_SIZE_LIMIT: limit_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_SCAN)
        begin
            q_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        if (q_scan_reg)
        begin
            if (!hit_f_reg && q_ent.item_size == req_reg.req_size[14:0])
            begin
                hit_idx_reg <= q_idx_reg;
            end
            if (q_ent.item_size == '0)
            begin
                emp_idx_reg <= q_idx_reg;
            end
        end

        case (ctl.op)
            OP_ACCEPT:
            begin
                req_reg        <= in_data;
                res_value_reg  <= '0;
                res_status_reg <= ST_OK;
            end
            OP_FAIL:
            begin
                res_value_reg  <= '0;
                res_status_reg <= ctl.code;
            end
            OP_PICK:
            begin
                sel_reg   <= hit_f_reg ? hit_idx_reg : emp_idx_reg;
                claim_reg <= !hit_f_reg;
            end
            OP_LOAD_ENTRY:
            begin
                w_size_reg <= claim_reg ? req_reg.req_size[14:0] : q_ent.item_size;
                w_rem_reg  <= claim_reg ? 15'd0 : q_ent.remaining;
                w_off_reg  <= q_ent.next_offset;
            end
            OP_RAW_REQ:
            begin
                sz_reg <= req_reg.req_size;
                al_reg <= req_reg.alignment;
            end
            OP_RAW_CHUNK:
            begin
                sz_reg <= CHUNK32;
                al_reg <= req_reg.req_size[15:0];
            end
            OP_BASE: base_reg <= base_calc;
            OP_END:  end_reg  <= end_calc;
            OP_X:    tmp_reg  <= x_calc;
            OP_CAP_X:
            begin
                res_value_reg  <= '0;
                res_status_reg <= ST_LIMIT;
            end
            OP_RAW_RESULT: res_value_reg <= base_reg[31:0];
            OP_CHUNK_OFF:  w_off_reg     <= base_reg[31:0];
            OP_CHUNK_REM:  w_rem_reg     <= div_q[14:0];
            OP_ITEM:
            begin
                w_rem_reg <= w_rem_reg - 15'd1;
                w_off_reg <= w_off_reg + req_reg.req_size;
            end
            OP_ITEM_RES: res_value_reg <= div_q;
            OP_EMIT:
            begin
                out_reg.result_value <= res_value_reg;
                out_reg.status       <= res_status_reg;
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb
    begin
        stat.is_raw      = req_reg.func == FUNC_RAW;
        stat.req_zero    = req_reg.req_size == '0;
        stat.req_big     = req_reg.req_size > CHUNK32;
        stat.div_busy    = div_busy;
        stat.scan_last   = q_scan_reg && (q_idx_reg == LAST_IDX);
        stat.hit_found   = hit_f_reg;
        stat.empty_found = emp_f_reg;
        stat.rem_zero    = w_rem_reg == '0;
        stat.aln_zero    = al_reg == '0;
        stat.end_ovf     = end_reg[33:32] != 2'b00;
        stat.end_fits    = end_reg[31:0] <= cap_reg;
        stat.at_limit    = (limit_reg != '0) && (cap_reg >= limit_reg);
        stat.step_zero   = step_reg == '0;
        stat.limit_on    = limit_reg != '0;
        stat.x_lt_end    = tmp_reg < end_reg[32:0];
        stat.out_free    = out_free;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_EMIT |-> out_free)
        else $error("result loaded while output register is held");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.status != ST_OK |-> out_reg.result_value == '0)
        else $error("failed request carries a nonzero value");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |-> !div_busy)
        else $error("divider started while busy");
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |=> div_busy)
        else $error("divider did not start");
`endif

endmodule

@@ hdl/pba_ctrl.sv @@
// ----------------------------------------------------------------------------
// pba_ctrl: allocator sequencer
// Steps one request through classification, pool scan, aligned bump,
// growth check and item carving, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module pba_ctrl
    import pba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output ctl_t  ctl
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_PICK,
        S_READ,
        S_LOAD,
        S_ENTRY,
        S_ALN,
        S_ALN_WAIT,
        S_BASE,
        S_END,
        S_CHK,
        S_CHK2,
        S_LIM_WAIT,
        S_X,
        S_XCHK,
        S_NEED_WAIT,
        S_Y,
        S_OK,
        S_CH_WAIT,
        S_CH_REM,
        S_ITEM,
        S_IT_WAIT,
        S_IT_RES,
        S_WB,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;
    state_t fail_to;

    // a failed pool request still writes back a claimed slot
    assign fail_to = stat.is_raw ? S_FINISH : S_WB;

    // next state and command
    always_comb
    begin
        state_next    = state_reg;
        ctl.op        = OP_NONE;
        ctl.div_start = 1'b0;
        ctl.div_sel   = DIV_ALN;
        ctl.code      = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op     = OP_ACCEPT;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_raw)
                begin
                    ctl.op     = OP_RAW_REQ;
                    state_next = S_ALN;
                end
                else if (stat.req_zero)
                begin
                    ctl.op     = OP_FAIL;
                    ctl.code   = ST_ZERO_SIZE;
                    state_next = S_FINISH;
                end
                else if (stat.req_big)
                begin
                    ctl.op     = OP_FAIL;
                    ctl.code   = ST_TOO_LARGE;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.op     = OP_SCAN_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.op = OP_SCAN;
                if (stat.scan_last)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (stat.hit_found || stat.empty_found)
                begin
                    ctl.op     = OP_PICK;
                    state_next = S_READ;
                end
                else
                begin
                    ctl.op     = OP_FAIL;
                    ctl.code   = ST_NO_POOL;
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                ctl.op     = OP_READ;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ctl.op     = OP_LOAD_ENTRY;
                state_next = S_ENTRY;
            end
            S_ENTRY:
            begin
                if (stat.rem_zero)
                begin
                    ctl.op     = OP_RAW_CHUNK;
                    state_next = S_ALN;
                end
                else
                begin
                    state_next = S_ITEM;
                end
            end
            // aligned bump
            S_ALN:
            begin
                if (stat.aln_zero)
                begin
                    state_next = S_BASE;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_ALN;
                    state_next    = S_ALN_WAIT;
                end
            end
            S_ALN_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                ctl.op     = OP_BASE;
                state_next = S_END;
            end
            S_END:
            begin
                ctl.op     = OP_END;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.end_ovf)
                begin
                    ctl.op     = OP_FAIL;
                    ctl.code   = ST_LIMIT;
                    state_next = fail_to;
                end
                else
                begin
                    ctl.op     = OP_COMMIT;
                    state_next = S_CHK2;
                end
            end
            // growth
            S_CHK2:
            begin
                if (stat.end_fits)
                begin
                    state_next = S_OK;
                end
                else if (stat.at_limit)
                begin
                    ctl.op     = OP_FAIL;
                    ctl.code   = ST_LIMIT;
                    state_next = fail_to;
                end
                else if (stat.step_zero)
                begin
                    ctl.op     = OP_FAIL;
                    ctl.code   = ST_NO_GROW;
                    state_next = fail_to;
                end
                else if (stat.limit_on)
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_LIM;
                    state_next    = S_LIM_WAIT;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_NEED;
                    state_next    = S_NEED_WAIT;
                end
            end
            S_LIM_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_X;
                end
            end
            S_X:
            begin
                ctl.op     = OP_X;
                state_next = S_XCHK;
            end
            S_XCHK:
            begin
                if (stat.x_lt_end)
                begin
                    ctl.op     = OP_CAP_X;
                    state_next = fail_to;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_NEED;
                    state_next    = S_NEED_WAIT;
                end
            end
            S_NEED_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_Y;
                end
            end
            S_Y:
            begin
                ctl.op     = OP_Y;
                state_next = S_OK;
            end
            S_OK:
            begin
                if (stat.is_raw)
                begin
                    ctl.op     = OP_RAW_RESULT;
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.op        = OP_CHUNK_OFF;
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_CHUNK;
                    state_next    = S_CH_WAIT;
                end
            end
            // chunk carve and item hand-out
            S_CH_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_CH_REM;
                end
            end
            S_CH_REM:
            begin
                ctl.op     = OP_CHUNK_REM;
                state_next = S_ITEM;
            end
            S_ITEM:
            begin
                ctl.op        = OP_ITEM;
                ctl.div_start = 1'b1;
                ctl.div_sel   = DIV_ITEM;
                state_next    = S_IT_WAIT;
            end
            S_IT_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_IT_RES;
                end
            end
            S_IT_RES:
            begin
                ctl.op     = OP_ITEM_RES;
                state_next = S_WB;
            end
            S_WB:
            begin
                ctl.op     = OP_WRITE;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctl.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= state_next != S_IDLE;
        end
    end

    assign in_stall = stall_reg;

endmodule
